// ===== design/least_squares_line_fit_defines.svh =====
// assertion macros shared by the line fit checker
`ifndef LEAST_SQUARES_LINE_FIT_DEFINES_SVH
`define LEAST_SQUARES_LINE_FIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LSLF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define LSLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define LSLF_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lslf_pkg.sv =====
// types and constants of the least squares line fit
`timescale 1ns / 1ps

package lslf_pkg;

  localparam int Q_FRAC      = 16;
  localparam int SHIFT_W     = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last_point;
  } sample_t;

  typedef enum logic [1:0] {
    FIT_OK       = 2'd0,
    FIT_ZERO_DEN = 2'd1,
    FIT_SAT      = 2'd2
  } fit_status_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    fit_status_t        fit_status;
  } fit_result_t;

  // product terms of the fit, in the order the back end forms them
  typedef enum logic [2:0] {
    TERM_N_SXX,
    TERM_SX_SX,
    TERM_N_SXY,
    TERM_SX_SY,
    TERM_SY_SXX,
    TERM_SX_SXY
  } term_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_MUL,
    BK_ACC,
    BK_DIV_SLOPE,
    BK_DIV_ICPT,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic               start;
    logic [SHIFT_W-1:0] shift;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== design/least_squares_line_fit.sv =====
// top level of the least squares line fit
`timescale 1ns / 1ps

// Takes one (x, y) pair per clock while busy is low; a pair is transferred when
// start is high and busy is low. Each pair is added into the running sums in
// the cycle it is transferred. The pair marked last closes the data set: its
// sums go into a two-entry queue and the back end forms the fit from it while
// the next data set streams in. The fit is sequential: up to six products on a
// shift-add multiplier of SQ_W steps each (SQ_W = 32 + log2(MAX_POINTS)) and
// two restoring divisions of ACC_W + 16 steps (ACC_W = 49 + 2*log2(MAX_POINTS));
// a zero denominator ends the fit after the first two products.
// busy rises only while both queue entries hold data sets waiting for the back
// end. The result is shown for exactly one cycle with done high; the receiver
// cannot stall it, so it must take it in that cycle.
module least_squares_line_fit import lslf_pkg::*; #(
  parameter int MAX_POINTS = 4096,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  sample_t     sample,
  output logic        done,
  output fit_result_t result
);

  localparam int LOG_N = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = 16 + LOG_N;
  localparam int SQ_W  = 32 + LOG_N;
  localparam int ACC_W = SUM_W + SQ_W + 1;
  localparam int ENT_W = CNT_W + 2 * SUM_W + 2 * SQ_W;

  logic                    push;
  logic [ENT_W-1:0]        push_data;
  logic                    pop;
  logic [ENT_W-1:0]        head;
  queue_status_t           qstat;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic signed [ACC_W-1:0] div_num;
  logic [ACC_W-1:0]        div_den;
  logic [31:0]             div_quot;

  assign busy = qstat.full;

  lslf_front #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W),
    .SQ_W       (SQ_W),
    .ENT_W      (ENT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .sample    (sample),
    .full      (qstat.full),
    .push      (push),
    .push_data (push_data)
  );

  lslf_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (push_data),
    .pop    (pop),
    .rdata  (head),
    .status (qstat)
  );

  lslf_div #(
    .NUM_W (ACC_W),
    .DEN_W (ACC_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .num      (div_num),
    .den      (div_den),
    .rsp      (div_rsp),
    .quotient (div_quot)
  );

  lslf_back #(
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .SQ_W      (SQ_W),
    .ENT_W     (ENT_W),
    .ACC_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .entry    (head),
    .pop      (pop),
    .div_req  (div_req),
    .div_num  (div_num),
    .div_den  (div_den),
    .div_rsp  (div_rsp),
    .div_quot (div_quot),
    .done     (done),
    .result   (result)
  );

endmodule

// ===== design/lslf_front.sv =====
// front end: accumulates sample pairs and hands finished data sets to the queue
`timescale 1ns / 1ps

module lslf_front import lslf_pkg::*; #(
  parameter int MAX_POINTS = 4096,
  parameter int CNT_W      = 13,
  parameter int SUM_W      = 28,
  parameter int SQ_W       = 44,
  parameter int ENT_W      = 157
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sample_t          sample,
  input  logic             full,
  output logic             push,
  output logic [ENT_W-1:0] push_data
);

  logic [CNT_W-1:0]        point_count;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SQ_W-1:0]  sum_x_squared;
  logic signed [SQ_W-1:0]  sum_x_times_y;

  logic [CNT_W-1:0]        point_count_next;
  logic signed [SUM_W-1:0] sum_x_next;
  logic signed [SUM_W-1:0] sum_y_next;
  logic signed [SQ_W-1:0]  sum_x_squared_next;
  logic signed [SQ_W-1:0]  sum_x_times_y_next;

  logic signed [15:0] x;
  logic signed [15:0] y;
  logic signed [31:0] prod_xx;
  logic signed [31:0] prod_xy;
  logic               accept;
  logic               room;

  always_comb begin
    x       = sample.x_value;
    y       = sample.y_value;
    prod_xx = x * x;
    prod_xy = x * y;
    accept  = start && !full;
    room    = point_count < CNT_W'(MAX_POINTS);

    point_count_next   = point_count;
    sum_x_next         = sum_x;
    sum_y_next         = sum_y;
    sum_x_squared_next = sum_x_squared;
    sum_x_times_y_next = sum_x_times_y;
    // pairs beyond the point limit are dropped
    if (room) begin
      point_count_next   = point_count + 1'b1;
      sum_x_next         = sum_x + {{(SUM_W-16){x[15]}}, x};
      sum_y_next         = sum_y + {{(SUM_W-16){y[15]}}, y};
      sum_x_squared_next = sum_x_squared + {{(SQ_W-32){prod_xx[31]}}, prod_xx};
      sum_x_times_y_next = sum_x_times_y + {{(SQ_W-32){prod_xy[31]}}, prod_xy};
    end

    push      = accept && sample.last_point;
    push_data = {point_count_next, sum_x_next, sum_y_next,
                 sum_x_squared_next, sum_x_times_y_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_x_squared <= '0;
      sum_x_times_y <= '0;
    end else if (accept) begin
      if (sample.last_point) begin
        point_count   <= '0;
        sum_x         <= '0;
        sum_y         <= '0;
        sum_x_squared <= '0;
        sum_x_times_y <= '0;
      end else begin
        point_count   <= point_count_next;
        sum_x         <= sum_x_next;
        sum_y         <= sum_y_next;
        sum_x_squared <= sum_x_squared_next;
        sum_x_times_y <= sum_x_times_y_next;
      end
    end
  end

endmodule

// ===== design/lslf_queue.sv =====
// short fifo of finished data sets between front and back end
`timescale 1ns / 1ps

module lslf_queue import lslf_pkg::*; #(
  parameter int WIDTH = 157,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output queue_status_t    status
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    status.full  = fill == FILL_W'(DEPTH);
    status.empty = fill == '0;
    do_push      = push && !status.full;
    do_pop       = pop && !status.empty;
    rdata        = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== design/lslf_div.sv =====
// restoring divider, one quotient bit per cycle, saturating signed 32-bit result (q16.16 when req.shift is Q_FRAC)
`timescale 1ns / 1ps

module lslf_div import lslf_pkg::*; #(
  parameter int NUM_W = 73,
  parameter int DEN_W = 73
) (
  input  logic                    clk,
  input  logic                    rst,
  input  div_req_t                req,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output div_rsp_t                rsp,
  output logic [31:0]             quotient
);

  localparam int DVD_W  = NUM_W + Q_FRAC;
  localparam int ITER_W = $clog2(DVD_W + 1);

  logic              running;
  logic [ITER_W-1:0] count;
  logic [DVD_W-1:0]  dvd;
  logic [DEN_W-1:0]  rem;
  logic [32:0]       q;
  logic              ovf;
  logic              neg;

  logic [NUM_W-1:0]  mag;
  logic [DEN_W-1:0]  trial;
  logic              fits;
  logic [32:0]       limit;
  logic              over;
  logic [31:0]       final_q;

  always_comb begin
    mag   = num[NUM_W-1] ? (~num + 1'b1) : num;
    // rem stays below den, which is below half the range, so the top bit is free
    trial = {rem[DEN_W-2:0], dvd[DVD_W-1]};
    fits  = trial >= den;
    limit = neg ? {1'b0, SAT_NEG} : {1'b0, SAT_POS};
    over  = ovf || (q > limit);
    if (over) begin
      final_q = neg ? SAT_NEG : SAT_POS;
    end else begin
      final_q = neg ? (~q[31:0] + 1'b1) : q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      rsp     <= '0;
    end else begin
      if (req.start) begin
        running  <= 1'b1;
        rsp.done <= 1'b0;
      end else if (running && count == '0) begin
        running  <= 1'b0;
        rsp.done <= 1'b1;
        rsp.sat  <= over;
      end else begin
        rsp.done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg   <= num[NUM_W-1];
      dvd   <= {{Q_FRAC{1'b0}}, mag} << req.shift;
      rem   <= '0;
      q     <= '0;
      ovf   <= 1'b0;
      count <= ITER_W'(DVD_W);
    end else if (running) begin
      if (count != '0) begin
        rem   <= fits ? trial - den : trial;
        q     <= {q[31:0], fits};
        ovf   <= ovf || q[32];
        dvd   <= {dvd[DVD_W-2:0], 1'b0};
        count <= count - 1'b1;
      end else begin
        quotient <= final_q;
      end
    end
  end

endmodule

// ===== design/lslf_back.sv =====
// back end: forms denominator and numerators with a serial multiplier, then divides
`timescale 1ns / 1ps

module lslf_back import lslf_pkg::*; #(
  parameter int CNT_W     = 13,
  parameter int SUM_W     = 28,
  parameter int SQ_W      = 44,
  parameter int ENT_W     = 157,
  parameter int ACC_W     = 73,
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  queue_status_t           qstat,
  input  logic [ENT_W-1:0]        entry,
  output logic                    pop,
  output div_req_t                div_req,
  output logic signed [ACC_W-1:0] div_num,
  output logic [ACC_W-1:0]        div_den,
  input  div_rsp_t                div_rsp,
  input  logic [31:0]             div_quot,
  output logic                    done,
  output fit_result_t             result
);

  localparam int MC_W = $clog2(SQ_W);

  back_state_t state;
  back_state_t state_next;
  term_t       term;
  term_t       term_succ;

  logic [CNT_W-1:0]        n_r;
  logic signed [SUM_W-1:0] sx_r;
  logic signed [SUM_W-1:0] sy_r;
  logic signed [SQ_W-1:0]  sxx_r;
  logic signed [SQ_W-1:0]  sxy_r;

  logic [SQ_W-1:0]         a_mag;
  logic [SQ_W-1:0]         b_mag;
  logic [ACC_W-1:0]        prod;
  logic                    prod_neg;
  logic [MC_W-1:0]         mul_count;
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0]        den;

  logic signed [31:0]      slope_r;
  logic signed [31:0]      icpt_r;
  logic                    slope_sat;
  fit_status_t             status_r;

  logic signed [SQ_W-1:0]  op_a;
  logic signed [SQ_W-1:0]  op_b;
  logic                    op_sub;
  logic [SQ_W-1:0]         op_a_mag;
  logic [SQ_W-1:0]         op_b_mag;
  logic                    op_neg;
  logic signed [ACC_W-1:0] acc_next;
  logic                    acc_zero;

  // operand decode for the current product term
  always_comb begin
    op_a      = '0;
    op_b      = '0;
    op_sub    = 1'b0;
    term_succ = term;
    unique case (term)
      TERM_N_SXX: begin
        op_a      = {{(SQ_W-CNT_W){1'b0}}, n_r};
        op_b      = sxx_r;
        term_succ = TERM_SX_SX;
      end
      TERM_SX_SX: begin
        op_a      = {{(SQ_W-SUM_W){sx_r[SUM_W-1]}}, sx_r};
        op_b      = {{(SQ_W-SUM_W){sx_r[SUM_W-1]}}, sx_r};
        op_sub    = 1'b1;
        term_succ = TERM_N_SXY;
      end
      TERM_N_SXY: begin
        op_a      = {{(SQ_W-CNT_W){1'b0}}, n_r};
        op_b      = sxy_r;
        term_succ = TERM_SX_SY;
      end
      TERM_SX_SY: begin
        op_a      = {{(SQ_W-SUM_W){sx_r[SUM_W-1]}}, sx_r};
        op_b      = {{(SQ_W-SUM_W){sy_r[SUM_W-1]}}, sy_r};
        op_sub    = 1'b1;
        term_succ = TERM_SY_SXX;
      end
      TERM_SY_SXX: begin
        op_a      = {{(SQ_W-SUM_W){sy_r[SUM_W-1]}}, sy_r};
        op_b      = sxx_r;
        term_succ = TERM_SX_SXY;
      end
      TERM_SX_SXY: begin
        op_a      = {{(SQ_W-SUM_W){sx_r[SUM_W-1]}}, sx_r};
        op_b      = sxy_r;
        op_sub    = 1'b1;
      end
      default: begin
      end
    endcase
    op_a_mag = op_a[SQ_W-1] ? (~op_a + 1'b1) : op_a;
    op_b_mag = op_b[SQ_W-1] ? (~op_b + 1'b1) : op_b;
    op_neg   = op_a[SQ_W-1] ^ op_b[SQ_W-1] ^ op_sub;
    acc_next = prod_neg ? acc - $signed(prod) : acc + $signed(prod);
    acc_zero = acc_next == '0;
  end

  always_comb begin
    state_next    = state;
    pop           = 1'b0;
    div_req.start = 1'b0;
    div_req.shift = SHIFT_W'(Q_FRAC);
    div_num       = acc_next;
    div_den       = den;
    done          = state == BK_EMIT;
    unique case (state)
      BK_IDLE: begin
        if (!qstat.empty) begin
          pop        = 1'b1;
          state_next = BK_SETUP;
        end
      end
      BK_SETUP: begin
        state_next = BK_MUL;
      end
      BK_MUL: begin
        if (mul_count == '0) begin
          state_next = BK_ACC;
        end
      end
      BK_ACC: begin
        unique case (term)
          TERM_SX_SX: begin
            state_next = acc_zero ? BK_EMIT : BK_SETUP;
          end
          TERM_SX_SY: begin
            div_req.start = 1'b1;
            state_next    = BK_DIV_SLOPE;
          end
          TERM_SX_SXY: begin
            div_req.start = 1'b1;
            div_req.shift = SHIFT_W'(Q_FRAC - FRAC_BITS);
            state_next    = BK_DIV_ICPT;
          end
          default: begin
            state_next = BK_SETUP;
          end
        endcase
      end
      BK_DIV_SLOPE: begin
        if (div_rsp.done) begin
          state_next = BK_SETUP;
        end
      end
      BK_DIV_ICPT: begin
        if (div_rsp.done) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) begin
          {n_r, sx_r, sy_r, sxx_r, sxy_r} <= entry;
          term <= TERM_N_SXX;
          acc  <= '0;
        end
      end
      BK_SETUP: begin
        a_mag     <= op_a_mag;
        b_mag     <= op_b_mag;
        prod_neg  <= op_neg;
        prod      <= '0;
        mul_count <= MC_W'(SQ_W - 1);
      end
      BK_MUL: begin
        // shift-add, multiplier bits taken from the top
        prod <= {prod[ACC_W-2:0], 1'b0}
              + (b_mag[SQ_W-1] ? {{(ACC_W-SQ_W){1'b0}}, a_mag} : '0);
        b_mag     <= {b_mag[SQ_W-2:0], 1'b0};
        mul_count <= mul_count - 1'b1;
      end
      BK_ACC: begin
        term <= term_succ;
        if (term == TERM_SX_SX) begin
          den <= acc_next;
          acc <= '0;
          if (acc_zero) begin
            slope_r  <= '0;
            icpt_r   <= '0;
            status_r <= FIT_ZERO_DEN;
          end
        end else if (term == TERM_SX_SY) begin
          acc <= '0;
        end else begin
          acc <= acc_next;
        end
      end
      BK_DIV_SLOPE: begin
        if (div_rsp.done) begin
          slope_r   <= div_quot;
          slope_sat <= div_rsp.sat;
        end
      end
      BK_DIV_ICPT: begin
        if (div_rsp.done) begin
          icpt_r   <= div_quot;
          status_r <= (slope_sat || div_rsp.sat) ? FIT_SAT : FIT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.slope      = slope_r;
    result.intercept  = icpt_r;
    result.fit_status = status_r;
  end

endmodule

// ===== design/lslf_checker.sv =====
// port-level checks of the line fit, bound to the top level
`timescale 1ns / 1ps
`include "least_squares_line_fit_defines.svh"

module lslf_checker import lslf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input fit_result_t result
);

  logic zero_den_shown;
  logic sat_shown;
  logic outputs_zero;
  logic output_on_rail;

  always_comb begin
    zero_den_shown = done && (result.fit_status == FIT_ZERO_DEN);
    sat_shown      = done && (result.fit_status == FIT_SAT);
    outputs_zero   = (result.slope == '0) && (result.intercept == '0);
    output_on_rail = (result.slope == SAT_POS) || (result.slope == SAT_NEG)
                  || (result.intercept == SAT_POS) || (result.intercept == SAT_NEG);
  end

  // queue not full (busy low) and no result shown right after reset
  `LSLF_ASSERT_ALWAYS(a_quiet_after_reset, clk, rst, !busy && !done, "busy or done after reset")

  // the back end goes from EMIT back to IDLE, so two results never come back to back
  `LSLF_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "done held longer than one cycle")

  // degenerate fit returns zeros
  `LSLF_ASSERT_SAME(a_zero_den_zero, clk, rst, zero_den_shown, outputs_zero, "zero fit not zero")

  // saturated status means at least one output sits at a rail
  `LSLF_ASSERT_SAME(a_sat_clamped, clk, rst, sat_shown, output_on_rail, "sat without clamp")

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== dv/tb.sv =====
// self-checking testbench for the least squares line fit
`timescale 1ns / 1ps

module tb;
  import lslf_pkg::*;

  localparam int MAX_POINTS   = 4096;
  localparam int FRAC_BITS    = 8;
  localparam int RANDOM_ITEMS = 1550;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 600;

  // value styles for generated data sets
  localparam int STYLE_FULL     = 0;
  localparam int STYLE_SMALL    = 1;
  localparam int STYLE_EXTREME  = 2;
  localparam int STYLE_SAME_X   = 3;
  localparam int STYLE_LINE     = 4;
  localparam int STYLE_MIXED    = 5;
  localparam int STYLE_ALL_MIN  = 6;

  typedef struct {
    sample_t     pair;
    bit          typed;
    fit_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst    = 1'b1;
  logic        start  = 1'b0;
  logic        busy;
  sample_t     sample = '0;
  logic        done;
  fit_result_t result;

  least_squares_line_fit #(
    .MAX_POINTS(MAX_POINTS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sample(sample),
    .done  (done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // running sums of the open data set
  logic signed [63:0] run_x, run_y, run_xx, run_xy;
  int unsigned        run_count;

  fit_result_t fits_due[$];
  stim_row_t   stim_table[$];
  int          errors    = 0;
  int          idle_pct  = 0;
  int          quiet_cycles = 0;

  // signed num * 2^shift / den, truncated toward zero, clamped to 32 bits
  function automatic logic [31:0] q16_quotient(input logic [127:0] num,
                                               input logic [63:0] den,
                                               input int unsigned shift,
                                               output bit clamped);
    logic         neg;
    logic [127:0] mag, quo, limit;
    neg     = num[127];
    mag     = neg ? -num : num;
    mag     = mag << shift;
    quo     = mag / {64'd0, den};
    limit   = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    clamped = 1'b0;
    if (quo > limit) begin
      clamped = 1'b1;
      return neg ? SAT_NEG : SAT_POS;
    end
    return neg ? -quo[31:0] : quo[31:0];
  endfunction

  task automatic fold_pair(input sample_t s, output bit closes, output fit_result_t fit);
    logic signed [127:0] n_w, sx, sy, sxx, sxy, d_full, m_num, b_num;
    logic [63:0]         den;
    bit                  clamp_m, clamp_b;
    if (run_count < MAX_POINTS) begin
      run_x  = run_x + s.x_value;
      run_y  = run_y + s.y_value;
      run_xx = run_xx + s.x_value * s.x_value;
      run_xy = run_xy + s.x_value * s.y_value;
      run_count++;
    end
    closes = s.last_point;
    fit    = '0;
    if (!closes) return;
    n_w    = run_count;
    sx     = run_x;
    sy     = run_y;
    sxx    = run_xx;
    sxy    = run_xy;
    d_full = n_w * sxx - sx * sx;
    den    = d_full[63:0];
    if (den == 64'd0) begin
      fit.fit_status = FIT_ZERO_DEN;
    end else begin
      m_num = n_w * sxy - sx * sy;
      b_num = sy * sxx - sx * sxy;
      fit.slope      = q16_quotient(m_num, den, Q_FRAC, clamp_m);
      fit.intercept  = q16_quotient(b_num, den, Q_FRAC - FRAC_BITS, clamp_b);
      fit.fit_status = (clamp_m || clamp_b) ? FIT_SAT : FIT_OK;
    end
    run_x     = '0;
    run_y     = '0;
    run_xx    = '0;
    run_xy    = '0;
    run_count = 0;
  endtask

  function automatic void add_row(input logic signed [15:0] x, input logic signed [15:0] y,
                                  input logic last, input bit typed,
                                  input logic [31:0] slope, input logic [31:0] icpt,
                                  input fit_status_t st);
    stim_row_t row;
    row.pair.x_value     = x;
    row.pair.y_value     = y;
    row.pair.last_point  = last;
    row.typed            = typed;
    row.want.slope       = slope;
    row.want.intercept   = icpt;
    row.want.fit_status  = st;
    stim_table.push_back(row);
  endfunction

  task automatic send_pair(input sample_t s, input bit typed, input fit_result_t want);
    bit          closes;
    fit_result_t fit;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    fold_pair(s, closes, fit);
    if (closes) fits_due.push_back(typed ? want : fit);
  endtask

  function automatic logic signed [15:0] draw(input int style);
    case (style)
      STYLE_SMALL: return 16'($signed($urandom_range(0, 1023)) - 512);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_set(input int npts, input int style);
    sample_t            s;
    logic signed [15:0] x0, offset;
    x0     = draw(STYLE_FULL);
    offset = draw(STYLE_SMALL);
    for (int i = 0; i < npts; i++) begin
      case (style)
        STYLE_SAME_X: begin
          s.x_value = x0;
          s.y_value = draw(STYLE_FULL);
        end
        STYLE_LINE: begin
          s.x_value = draw(STYLE_SMALL);
          s.y_value = offset + (s.x_value >>> 1) + 16'($signed($urandom_range(0, 2)) - 1);
        end
        STYLE_MIXED: begin
          s.x_value = draw($urandom_range(STYLE_FULL, STYLE_EXTREME));
          s.y_value = draw($urandom_range(STYLE_FULL, STYLE_EXTREME));
        end
        STYLE_ALL_MIN: begin
          s.x_value = 16'sh8000;
          s.y_value = 16'sh8000;
        end
        default: begin
          s.x_value = draw(style);
          s.y_value = draw(style);
        end
      endcase
      s.last_point = (i == npts - 1);
      send_pair(s, 1'b0, '0);
    end
  endtask

  // result check against the oldest expected fit
  always @(posedge clk) begin
    fit_result_t want;
    if (!rst && done) begin
      if (fits_due.size() == 0) begin
        $error("fit result with none expected: slope %0d intercept %0d status %0d",
               result.slope, result.intercept, result.fit_status);
        errors++;
      end else begin
        want = fits_due.pop_front();
        if (result.slope !== want.slope) begin
          $error("slope: expected %0d, got %0d", want.slope, result.slope);
          errors++;
        end
        if (result.intercept !== want.intercept) begin
          $error("intercept: expected %0d, got %0d", want.intercept, result.intercept);
          errors++;
        end
        if (result.fit_status !== want.fit_status) begin
          $error("fit_status: expected %0d, got %0d", want.fit_status, result.fit_status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int phase_pct[4];
    int sent, npts;
    phase_pct = '{0, 50, 0, 24};
    run_x     = '0;
    run_y     = '0;
    run_xx    = '0;
    run_xy    = '0;
    run_count = 0;

    // single point, then all x equal: no unique line
    add_row(0, 0, 1'b1, 1'b1, 32'd0, 32'd0, FIT_ZERO_DEN);
    add_row(100, 5, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(100, -7, 1'b1, 1'b1, 32'd0, 32'd0, FIT_ZERO_DEN);
    // y = x: slope 1.0, intercept 0
    add_row(0, 0, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(256, 256, 1'b1, 1'b1, 32'h0001_0000, 32'd0, FIT_OK);
    // steepest rise and fall clamp the slope
    add_row(0, -32768, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(1, 32767, 1'b1, 1'b1, SAT_POS, -32'sd8388608, FIT_SAT);
    add_row(0, 32767, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(1, -32768, 1'b1, 1'b1, SAT_NEG, 32'sd8388352, FIT_SAT);
    // field extremes
    add_row(-32768, -32768, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(32767, 32767, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(-1, 0, 1'b1, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(32767, -32768, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(-32768, 32767, 1'b1, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(-512, 300, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(0, 100, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(512, -100, 1'b1, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(5, 9, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(5, 9, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(5, 9, 1'b0, 1'b0, 32'd0, 32'd0, FIT_OK);
    add_row(6, -9, 1'b1, 1'b0, 32'd0, 32'd0, FIT_OK);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_table[i]) send_pair(stim_table[i].pair, stim_table[i].typed, stim_table[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      sent     = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        npts = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        send_set(npts, $urandom_range(STYLE_FULL, STYLE_ALL_MIN));
        sent += npts;
      end
    end
    start <= 1'b0;

    while (fits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
